@@ hw/rtl/packet_byte_deframer_defines.svh @@
// Assertion helpers used by the deframer core (pbd_core).
`ifndef PACKET_BYTE_DEFRAMER_DEFINES_SVH
`define PACKET_BYTE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbd check failed: same cycle");

// Next-cycle implication, disabled while in reset.
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbd check failed: next cycle");

`endif

@@ hw/rtl/pbd_pkg.sv @@
package pbd_pkg;

    // frame phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_FOOT = 2'd3;

    // per-beat status codes
    localparam logic [1:0] ST_ACCEPT   = 2'd0;
    localparam logic [1:0] ST_DISCARD  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_FLUSHED  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_START_SYMBOL    = 2'd0;
    localparam logic [1:0] CFG_END_SYMBOL      = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd2;
    localparam logic [1:0] CFG_FRAME_CAPACITY  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [7:0]  RST_START_SYMBOL    = 8'd170;
    localparam logic [7:0]  RST_END_SYMBOL      = 8'd85;
    localparam logic [15:0] RST_MAX_PAYLOAD_LEN = 16'd1024;
    localparam logic [15:0] RST_FRAME_CAPACITY  = 16'd1033;

    // start, command and two length bytes
    localparam logic [16:0] HEAD_LEN = 17'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       flush;
    } pbd_in_t;

    typedef struct packed {
        logic [1:0]  byte_status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [7:0]  command;
        logic [15:0] payload_length;
        logic [15:0] frame_flags;
        logic        length_error;
        logic        checksum_error;
        logic        end_error;
    } pbd_out_t;

    typedef struct packed {
        logic [7:0]  start_symbol;
        logic [7:0]  end_symbol;
        logic [15:0] max_payload_len;
        logic [15:0] frame_capacity;
    } pbd_cfg_t;

endpackage

@@ hw/rtl/packet_byte_deframer.sv @@
// A beat waits in the input register; its result is held in the output register on out_data.
// Throughput: one beat per cycle unless out_ready stalls; work is 16-bit adds and compares.
// An input register and an output register let a new beat in while a result waits.
// Reset (rst_n low, async): config back to defaults, frame state to waiting, no beats held.
module packet_byte_deframer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pbd_pkg::pbd_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pbd_pkg::pbd_out_t                   out_data,
    input  logic                                cfg_we,
    input  logic [pbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pbd_pkg::*;

    pbd_cfg_t cfg_reg;
    pbd_in_t  in_beat_reg;
    logic     in_valid_reg;
    pbd_out_t out_data_reg;
    logic     out_valid_reg;
    pbd_out_t result;
    logic     advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_symbol    <= RST_START_SYMBOL;
            cfg_reg.end_symbol      <= RST_END_SYMBOL;
            cfg_reg.max_payload_len <= RST_MAX_PAYLOAD_LEN;
            cfg_reg.frame_capacity  <= RST_FRAME_CAPACITY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_SYMBOL:    cfg_reg.start_symbol    <= cfg_data[7:0];
                CFG_END_SYMBOL:      cfg_reg.end_symbol      <= cfg_data[7:0];
                CFG_MAX_PAYLOAD_LEN: cfg_reg.max_payload_len <= cfg_data;
                CFG_FRAME_CAPACITY:  cfg_reg.frame_capacity  <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_beat_reg <= in_data;
        end
    end

    pbd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (in_beat_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hw/rtl/pbd_core.sv @@
`include "packet_byte_deframer_defines.svh"

module pbd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  pbd_pkg::pbd_in_t  beat,
    input  pbd_pkg::pbd_cfg_t cfg,
    output pbd_pkg::pbd_out_t result
);
    import pbd_pkg::*;

    logic [1:0]  phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] flags_reg,   flags_next;
    logic [15:0] sum_reg,     sum_next;
    logic [7:0]  ck_high_reg, ck_high_next;

    logic [16:0] frame_base;
    logic [16:0] foot_off;
    logic [15:0] count_inc;
    logic [15:0] length_lo;
    logic        too_long;

    assign frame_base = HEAD_LEN + {1'b0, length_reg};
    // footer offset; a negative difference lands far above 3
    assign foot_off   = {1'b0, count_reg} - frame_base;
    assign count_inc  = count_reg + 16'd1;
    assign length_lo  = {length_reg[15:8], beat.rx_byte};
    assign too_long   = length_reg > cfg.max_payload_len;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        command_next = command_reg;
        flags_next   = flags_reg;
        sum_next     = sum_reg;
        ck_high_next = ck_high_reg;
        result       = '0;

        if (beat.flush)
        begin
            result.byte_status = ST_FLUSHED;
            phase_next = PH_WAIT;
            count_next = '0;
        end
        else if (phase_reg == PH_WAIT)
        begin
            if (beat.rx_byte != cfg.start_symbol)
            begin
                result.byte_status = ST_DISCARD;
            end
            else if (cfg.frame_capacity == '0)
            begin
                result.byte_status = ST_OVERFLOW;
            end
            else
            begin
                count_next = 16'd1;
                sum_next   = {8'd0, beat.rx_byte};
                phase_next = PH_HEAD;
            end
        end
        else if (count_reg >= cfg.frame_capacity)
        begin
            result.byte_status = ST_OVERFLOW;
            phase_next = PH_WAIT;
            count_next = '0;
        end
        else
        begin
            count_next = count_inc;
            case (phase_reg)
                PH_HEAD:
                begin
                    sum_next = sum_reg + {8'd0, beat.rx_byte};
                    if (count_reg == 16'd1)
                    begin
                        command_next = beat.rx_byte;
                    end
                    else if (count_reg == 16'd2)
                    begin
                        length_next = {beat.rx_byte, 8'd0};
                    end
                    else
                    begin
                        length_next = length_lo;
                        phase_next  = (length_lo == '0) ? PH_FOOT : PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    sum_next = sum_reg + {8'd0, beat.rx_byte};
                    if (!too_long)
                    begin
                        result.payload_valid = 1'b1;
                        result.payload_byte  = beat.rx_byte;
                    end
                    if ({1'b0, count_inc} == frame_base)
                    begin
                        phase_next = PH_FOOT;
                    end
                end
                PH_FOOT:
                begin
                    case (foot_off)
                        17'd0:
                        begin
                            flags_next = {beat.rx_byte, 8'd0};
                            sum_next   = sum_reg + {8'd0, beat.rx_byte};
                        end
                        17'd1:
                        begin
                            flags_next = {flags_reg[15:8], beat.rx_byte};
                            sum_next   = sum_reg + {8'd0, beat.rx_byte};
                        end
                        17'd2:
                        begin
                            ck_high_next = beat.rx_byte;
                        end
                        17'd3:
                        begin
                            sum_next = sum_reg + {ck_high_reg, beat.rx_byte};
                        end
                        default:
                        begin
                            // end symbol slot: report the frame
                            result.frame_done     = 1'b1;
                            result.command        = command_reg;
                            result.payload_length = length_reg;
                            if (too_long)
                            begin
                                result.length_error = 1'b1;
                            end
                            else
                            begin
                                result.frame_flags    = flags_reg;
                                result.checksum_error = (sum_reg != '0);
                                result.end_error      = (beat.rx_byte != cfg.end_symbol);
                            end
                            phase_next = PH_WAIT;
                            count_next = '0;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            count_reg   <= '0;
            length_reg  <= '0;
            command_reg <= '0;
            flags_reg   <= '0;
            sum_reg     <= '0;
            ck_high_reg <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            command_reg <= command_next;
            flags_reg   <= flags_next;
            sum_reg     <= sum_next;
            ck_high_reg <= ck_high_next;
        end
    end

    `PBD_ASSERT_NEXT(a_flush_to_wait, clk, rst_n, step && beat.flush, (phase_reg == PH_WAIT) && (count_reg == '0))
    `PBD_ASSERT_NOW(a_frame_has_count, clk, rst_n, phase_reg != PH_WAIT, count_reg != '0)
    `PBD_ASSERT_NOW(a_done_is_accept, clk, rst_n, step && result.frame_done, (result.byte_status == ST_ACCEPT) && !result.payload_valid)
    `PBD_ASSERT_NOW(a_len_err_masks, clk, rst_n, step && result.length_error, (result.frame_flags == '0) && !result.checksum_error && !result.end_error)
    `PBD_ASSERT_NEXT(a_done_to_wait, clk, rst_n, step && result.frame_done, (phase_reg == PH_WAIT) && (count_reg == '0))

endmodule
